[rtl/core/kcrw_pkg.sv]
`timescale 1ns / 1ps
// kcrw_pkg: constants, register codes and types for keyed_counter_random_word
// no dependencies; imported by the top level

package kcrw_pkg;

   // splitmix64 round constants
   localparam logic [63:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;
   localparam logic [63:0] SEED_TAG    = 64'h5332_5f52_4e47_5f31;

   localparam int SHIFT_1 = 30;
   localparam int SHIFT_2 = 27;
   localparam int SHIFT_3 = 31;

   // eight rounds, five register stages each
   localparam int NUM_ROUNDS       = 8;
   localparam int STAGES_PER_ROUND = 5;
   localparam int NUM_STAGES       = NUM_ROUNDS * STAGES_PER_ROUND;

   // tag folded in before each round
   localparam logic [63:0] ROUND_TAG [NUM_ROUNDS] = '{
      SEED_TAG, 64'h1, 64'h2, 64'h3, 64'h4, 64'h5, 64'h6, 64'h7
   };

   // configuration register indexes
   localparam int CSR_INDEX_W = 8;
   localparam int CFG_COUNT   = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MASTER_SEED     = 8'd0,
      REG_STAGE_HASH      = 8'd1,
      REG_CASE_HASH       = 8'd2,
      REG_SNR_POINT_INDEX = 8'd3
   } csr_reg_type;

   // key fields of one item as they travel down the pipe
   typedef struct packed {
      logic [63:0] frame_number;
      logic [7:0]  domain_code;
      logic [63:0] symbol_number;
      logic [63:0] lane_number;
   } item_type;

endpackage

[rtl/core/keyed_counter_random_word.sv]
`timescale 1ns / 1ps
// keyed_counter_random_word: pipelined splitmix64 chain, one random word per key
// depends on kcrw_pkg
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  csr     | in  | csr_valid/csr_ready  | csr_index (register), csr_data (64 bits)
//  req     | in  | req_tvalid/tready    | tdata: frame, symbol, lane; tuser: domain
//  rsp     | out | rsp_tvalid/tready    | tdata: random_word
//
// one beat in and one beat out per cycle while rsp is ready and the skid is empty;
// each key passes eight rounds of five stages each (the 64-bit multiplies are split
// into 32-bit partial products and summed a stage later), then the output register.
// reset is synchronous, active high, and clears valid bits and config registers.
// a stall on rsp fills a one-entry skid; the pipe freezes only while it is full.

module keyed_counter_random_word
   import kcrw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_data,
   // key beats
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [191:0]           req_tdata,  // frame_number, symbol_number, lane_number
   input  logic [7:0]             req_tuser,  // domain_code
   // random word beats
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata   // random_word
);

   // configuration registers
   logic [63:0] cfg_ff [CFG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_COUNT; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MASTER_SEED:     cfg_ff[0] <= csr_data;
            REG_STAGE_HASH:      cfg_ff[1] <= csr_data;
            REG_CASE_HASH:       cfg_ff[2] <= csr_data;
            REG_SNR_POINT_INDEX: cfg_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // pipe enable and input side
   logic     pipe_en;
   logic     skid_valid_ff;
   item_type req_item;

   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;

   always_comb begin
      req_item.frame_number  = req_tdata[63:0];
      req_item.domain_code   = req_tuser;
      req_item.symbol_number = req_tdata[127:64];
      req_item.lane_number   = req_tdata[191:128];
   end

   // valid bits and key fields travel with every stage
   logic     valid_ff [NUM_STAGES];
   item_type fld_ff   [NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (pipe_en) begin
         valid_ff[0] <= req_tvalid;
         for (int s = 1; s < NUM_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fld_ff[0] <= req_item;
         for (int s = 1; s < NUM_STAGES; s++) begin
            fld_ff[s] <= fld_ff[s-1];
         end
      end
   end

   // per-round datapath registers
   logic [63:0] a_ff   [NUM_ROUNDS];  // after key mix, golden add, first xorshift
   logic [63:0] pl_ff  [NUM_ROUNDS];  // low x low partial product, first multiply
   logic [31:0] pm1_ff [NUM_ROUNDS];  // cross partial products, first multiply
   logic [31:0] pm2_ff [NUM_ROUNDS];
   logic [63:0] c_ff   [NUM_ROUNDS];  // after first multiply and second xorshift
   logic [63:0] ql_ff  [NUM_ROUNDS];  // partial products, second multiply
   logic [31:0] qm1_ff [NUM_ROUNDS];
   logic [31:0] qm2_ff [NUM_ROUNDS];
   logic [63:0] e_ff   [NUM_ROUNDS];  // round result

   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      logic [63:0] v_prev;
      item_type    f_prev;
      logic [63:0] key_part;
      logic [63:0] sum_a;
      logic [63:0] a_in;
      logic [63:0] prod_ll_a;
      logic [31:0] prod_lh_a;
      logic [31:0] prod_hl_a;
      logic [63:0] sum_c;
      logic [63:0] c_in;
      logic [63:0] prod_ll_b;
      logic [31:0] prod_lh_b;
      logic [31:0] prod_hl_b;
      logic [63:0] sum_e;
      logic [63:0] e_in;

      // value and fields entering this round
      if (r == 0) begin : g_first
         assign v_prev = '0;
         assign f_prev = req_item;
      end else begin : g_next
         assign v_prev = e_ff[r-1];
         assign f_prev = fld_ff[r*STAGES_PER_ROUND-1];
      end

      // key part of this round
      always_comb begin
         case (r)
            0:       key_part = cfg_ff[0];
            1:       key_part = cfg_ff[1];
            2:       key_part = cfg_ff[2];
            3:       key_part = cfg_ff[3];
            4:       key_part = f_prev.frame_number;
            5:       key_part = {56'd0, f_prev.domain_code};
            6:       key_part = f_prev.symbol_number;
            7:       key_part = f_prev.lane_number;
            default: key_part = '0;
         endcase
      end

      // stage 0: key mix, golden step, first xorshift
      assign sum_a = (v_prev ^ key_part ^ ROUND_TAG[r]) + GOLDEN_STEP;
      assign a_in  = sum_a ^ (sum_a >> SHIFT_1);

      // stage 1: partial products of the first multiply, cross terms kept mod 2^32
      assign prod_ll_a = 64'(a_ff[r][31:0]) * 64'(MIX_MUL_A[31:0]);
      assign prod_lh_a = a_ff[r][31:0]  * MIX_MUL_A[63:32];
      assign prod_hl_a = a_ff[r][63:32] * MIX_MUL_A[31:0];

      // stage 2: sum partials, second xorshift
      assign sum_c = pl_ff[r] + {pm1_ff[r] + pm2_ff[r], 32'd0};
      assign c_in  = sum_c ^ (sum_c >> SHIFT_2);

      // stage 3: partial products of the second multiply
      assign prod_ll_b = 64'(c_ff[r][31:0]) * 64'(MIX_MUL_B[31:0]);
      assign prod_lh_b = c_ff[r][31:0]  * MIX_MUL_B[63:32];
      assign prod_hl_b = c_ff[r][63:32] * MIX_MUL_B[31:0];

      // stage 4: sum partials, final xorshift
      assign sum_e = ql_ff[r] + {qm1_ff[r] + qm2_ff[r], 32'd0};
      assign e_in  = sum_e ^ (sum_e >> SHIFT_3);

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            a_ff[r]   <= a_in;
            pl_ff[r]  <= prod_ll_a;
            pm1_ff[r] <= prod_lh_a;
            pm2_ff[r] <= prod_hl_a;
            c_ff[r]   <= c_in;
            ql_ff[r]  <= prod_ll_b;
            qm1_ff[r] <= prod_lh_b;
            qm2_ff[r] <= prod_hl_b;
            e_ff[r]   <= e_in;
         end
      end
   end

   // output register with one-entry skid
   logic        pipe_beat;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic        skid_valid_in;
   logic [63:0] skid_data_ff, skid_data_in;

   assign pipe_beat = pipe_en && valid_ff[NUM_STAGES-1];

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = pipe_beat;
            out_data_in  = e_ff[NUM_ROUNDS-1];
         end
      end else if (pipe_beat) begin
         skid_valid_in = 1'b1;
         skid_data_in  = e_ff[NUM_ROUNDS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for keyed_counter_random_word, splitmix64 chain per key
// depends on kcrw_pkg and rtl/core/keyed_counter_random_word.sv

module tb;
   import kcrw_pkg::*;

   // indexes past the register file, writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LOW  = CSR_INDEX_W'(CFG_COUNT);
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_HIGH = '1;

   localparam int RANDOM_PER_PHASE = 300;
   localparam int NUM_PHASES       = 6;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int DRAIN_CYCLES     = 60;

   typedef struct packed {
      logic [63:0] frame_number;
      logic [7:0]  domain_code;
      logic [63:0] symbol_number;
      logic [63:0] lane_number;
   } key_type;

   // directed keys: extremes, single bits, patterns and a repeated key
   localparam int NUM_DIRECTED = 18;
   localparam key_type DIRECTED_KEYS [NUM_DIRECTED] = '{
      '{64'h0, 8'h00, 64'h0, 64'h0},
      '{'1, 8'hff, '1, '1},
      '{'1, 8'h00, 64'h0, 64'h0},
      '{64'h0, 8'hff, 64'h0, 64'h0},
      '{64'h0, 8'h00, '1, 64'h0},
      '{64'h0, 8'h00, 64'h0, '1},
      '{64'h1, 8'h01, 64'h1, 64'h1},
      '{64'h0, 8'h00, 64'h0, 64'h1},
      '{64'h8000_0000_0000_0000, 8'h80, 64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0000},
      '{64'h5555_5555_5555_5555, 8'h55, 64'haaaa_aaaa_aaaa_aaaa,
        64'h5555_5555_5555_5555},
      '{64'haaaa_aaaa_aaaa_aaaa, 8'haa, 64'h5555_5555_5555_5555,
        64'haaaa_aaaa_aaaa_aaaa},
      '{64'h0000_0000_ffff_ffff, 8'h0f, 64'hffff_ffff_0000_0000, 64'h0},
      '{64'hffff_ffff_0000_0000, 8'hf0, 64'h0000_0000_ffff_ffff, 64'h1},
      '{64'h7fff_ffff_ffff_ffff, 8'h7f, 64'h7fff_ffff_ffff_ffff,
        64'h7fff_ffff_ffff_ffff},
      '{64'h0000_0000_0000_0004, 8'h05, 64'h6, 64'h7},
      '{64'h2a, 8'h02, 64'h3e8, 64'h0},
      '{64'h2a, 8'h02, 64'h3e8, 64'h0},
      '{64'h2a, 8'h02, 64'h3e8, 64'h1}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [191:0]           req_tdata = '0;  // frame_number, symbol_number, lane_number
   logic [7:0]             req_tuser = '0;  // domain_code
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [63:0]            rsp_tdata;       // random_word

   // bench copy of the key registers and the words still owed by the block
   logic [63:0] key_reg [CFG_COUNT];
   logic [63:0] pending_words [$];
   int          error_count = 0;

   // idling controls for the sender tasks and the receiver process
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   bit long_hold_request = 1'b0;
   int long_hold_left    = 0;

   keyed_counter_random_word u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one splitmix64 round
   function automatic logic [63:0] splitmix_round(logic [63:0] x);
      logic [63:0] y;
      y = x + GOLDEN_STEP;
      y = (y ^ (y >> SHIFT_1)) * MIX_MUL_A;
      y = (y ^ (y >> SHIFT_2)) * MIX_MUL_B;
      return y ^ (y >> SHIFT_3);
   endfunction

   // fold registers and key through the eight tagged rounds
   function automatic logic [63:0] keyed_word(key_type k);
      logic [63:0] part [NUM_ROUNDS];
      logic [63:0] v;
      part[0] = key_reg[REG_MASTER_SEED];
      part[1] = key_reg[REG_STAGE_HASH];
      part[2] = key_reg[REG_CASE_HASH];
      part[3] = key_reg[REG_SNR_POINT_INDEX];
      part[4] = k.frame_number;
      part[5] = {56'h0, k.domain_code};
      part[6] = k.symbol_number;
      part[7] = k.lane_number;
      v = '0;
      for (int i = 0; i < NUM_ROUNDS; i++) begin
         v = splitmix_round(v ^ part[i] ^ ROUND_TAG[i]);
      end
      return v;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random key: a quarter counter-like, a quarter with fields forced to all ones or zeros, the rest noise
   function automatic key_type random_key();
      key_type k;
      k.frame_number  = rand64();
      k.domain_code   = 8'($urandom_range(255));
      k.symbol_number = rand64();
      k.lane_number   = rand64();
      case ($urandom_range(3))
         0: begin
            k.frame_number  = 64'($urandom_range(5000));
            k.symbol_number = 64'($urandom_range(2047));
            k.lane_number   = 64'($urandom_range(1));
            k.domain_code   = 8'($urandom_range(7));
         end
         1: begin
            if ($urandom_range(1)) k.frame_number = $urandom_range(1) ? '1 : '0;
            if ($urandom_range(1)) k.symbol_number = $urandom_range(1) ? '1 : '0;
            if ($urandom_range(1)) k.lane_number = $urandom_range(1) ? '1 : '0;
         end
         default: ;
      endcase
      return k;
   endfunction

   // bookkeeping at the rising edge: register writes, key beats, word beats
   always @(posedge clock) begin
      if (reset) begin
         foreach (key_reg[i]) key_reg[i] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MASTER_SEED:     key_reg[REG_MASTER_SEED]     = csr_data;
               REG_STAGE_HASH:      key_reg[REG_STAGE_HASH]      = csr_data;
               REG_CASE_HASH:       key_reg[REG_CASE_HASH]       = csr_data;
               REG_SNR_POINT_INDEX: key_reg[REG_SNR_POINT_INDEX] = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               $error("random_word: expected none, actual %h", rsp_tdata);
               error_count++;
            end else begin
               logic [63:0] want;
               want = pending_words.pop_front();
               if (rsp_tdata !== want) begin
                  $error("random_word: expected %h, actual %h", want, rsp_tdata);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            key_type k;
            k.frame_number  = req_tdata[63:0];
            k.symbol_number = req_tdata[127:64];
            k.lane_number   = req_tdata[191:128];
            k.domain_code   = req_tuser;
            pending_words.push_back(keyed_word(k));
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (long_hold_request) begin
         long_hold_left = LONG_HOLD_CYCLES;
         long_hold_request = 1'b0;
      end
      if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // offer one key beat, idling first as the sender mode asks
   task automatic send_key(key_type k);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {k.lane_number, k.symbol_number, k.frame_number};
      req_tuser  <= k.domain_code;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and wait until every owed word has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_keys(logic [63:0] seed, logic [63:0] stage,
                            logic [63:0] case_id, logic [63:0] snr);
      csr_write(REG_MASTER_SEED, seed);
      csr_write(REG_STAGE_HASH, stage);
      csr_write(REG_CASE_HASH, case_id);
      csr_write(REG_SNR_POINT_INDEX, snr);
   endtask

   // main sequence
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed keys under reset register values
      foreach (DIRECTED_KEYS[i]) send_key(DIRECTED_KEYS[i]);
      wait_drained();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               load_keys('1, '1, '1, '1);
               csr_write(REG_UNUSED_LOW, rand64());
               csr_write(REG_UNUSED_HIGH, rand64());
               sender_idle_pct = 0;  receiver_stall_pct = 0;
            end
            1: begin
               load_keys(rand64(), rand64(), rand64(), 64'($urandom_range(40)));
               sender_idle_pct = 72; receiver_stall_pct = 0;
            end
            2: begin
               load_keys(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                         64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
               sender_idle_pct = 0;  receiver_stall_pct = 72;
            end
            3: begin
               load_keys(rand64(), rand64(), rand64(), rand64());
               csr_write(REG_UNUSED_LOW, '1);
               sender_idle_pct = 9;  receiver_stall_pct = 9;
            end
            4: begin
               load_keys('0, '0, '0, '0);
               sender_idle_pct = 9;  receiver_stall_pct = 9;
            end
            default: begin
               load_keys(rand64(), rand64(), rand64(), 64'($urandom_range(1)));
               sender_idle_pct = 0;  receiver_stall_pct = 0;
            end
         endcase

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // long receiver hold-off while keys keep coming, fills the pipe
            if (n == 100 && (phase == 2 || phase == 5)) long_hold_request = 1'b1;
            // sender pause until the block has handed back everything
            if (n == 150 && phase == 4) wait_drained();
            send_key(random_key());
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/kcrw_pkg.sv
rtl/core/keyed_counter_random_word.sv
bench/tb.sv
